// ===== hw/rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the trie dictionary block.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/twil_pkg.sv =====
// -----------------------------------------------------------------------------
// twil_pkg
// Types, sizes and the character-to-symbol map of the trie dictionary.
// -----------------------------------------------------------------------------
`default_nettype none

package twil_pkg;

   localparam int NODE_COUNT   = 1024;
   localparam int SYMBOL_SLOTS = 28;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int FREE_W       = NODE_W + 1;
   localparam int LINK_DEPTH   = NODE_COUNT * SYMBOL_SLOTS;
   localparam int LINK_AW      = $clog2(LINK_DEPTH);
   localparam int SYM_W        = 5;
   localparam int WORD_W       = 10;

   localparam logic [WORD_W-1:0] WORD_MAX = 10'd1023;

   localparam logic [7:0] CHAR_APOS    = 8'd39;
   localparam logic [7:0] LOWER_BASE   = 8'd96;
   localparam logic [7:0] LOWER_END    = 8'd123;
   localparam logic [7:0] UPPER_BASE   = 8'd64;
   localparam logic [7:0] UPPER_END    = 8'd91;
   localparam logic [SYM_W-1:0] SYM_APOS = 5'd27;
   localparam logic [SYM_W-1:0] SYM_END  = 5'd0;

   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_LOAD  = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] word_total;
      logic              pool_full;
      logic              was_load;
   } rsp_type;

   typedef struct packed {
      logic               link_re;
      logic               link_we;
      logic [LINK_AW-1:0] link_addr;
      logic [NODE_W-1:0]  link_wdata;
      logic               mark_re;
      logic               mark_we;
      logic [NODE_W-1:0]  mark_addr;
   } mem_req_type;

   typedef struct packed {
      logic               busy;
      logic [LINK_AW-1:0] addr;
   } clr_type;

   function automatic logic [SYM_W-1:0] symbol_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c == CHAR_APOS) begin
         d = {3'd0, SYM_APOS};
      end else if (c > LOWER_BASE && c < LOWER_END) begin
         d = c - LOWER_BASE;
      end else if (c > UPPER_BASE && c < UPPER_END) begin
         d = c - UPPER_BASE;
      end
      return d[SYM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/twil_ram.sv =====
// -----------------------------------------------------------------------------
// twil_ram
// Generic single-port RAM, registered read; the user must keep write and read in separate cycles, unchecked here.
// -----------------------------------------------------------------------------
`default_nettype none

module twil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/twil_clear.sv =====
// -----------------------------------------------------------------------------
// twil_clear
// Post-reset sweep that zeroes the link and end-mark memories.
// -----------------------------------------------------------------------------
`default_nettype none

module twil_clear
   import twil_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   output clr_type   clr
);

   logic [LINK_AW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + LINK_AW'(1);
         if (cnt_ff == LINK_AW'(LINK_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign clr.busy = busy_ff;
   assign clr.addr = cnt_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/twil_ctrl.sv =====
// -----------------------------------------------------------------------------
// twil_ctrl
// Trie walker: read child link, decide, write back, register the result.
// -----------------------------------------------------------------------------
`default_nettype none

module twil_ctrl
   import twil_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clr_busy,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_payload,
   output mem_req_type            mem,
   input  wire logic [NODE_W-1:0] link_rdata,
   input  wire logic              mark_rdata
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic [WORD_W-1:0]  words_ff, words_in;
   logic               missed_ff, missed_in;
   logic               ovf_ff, ovf_in;
   logic               load_ff, load_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [LINK_AW-1:0] addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [SYM_W-1:0]   req_sym;
   logic               mark_eff;
   logic               has_result;
   logic               stall;

   always_comb begin
      req_sym    = symbol_of(req_payload.char_code);
      mark_eff   = (node_ff == '0) | mark_rdata;
      has_result = (sym_ff == SYM_END) &&
                   !(load_ff == ACT_LOAD && node_ff == '0 && !ovf_ff);
      stall      = has_result && rsp_valid_ff && !rsp_ready;
      req_ready  = (state_ff == ST_IDLE) && !clr_busy;

      state_in     = state_ff;
      node_in      = node_ff;
      free_in      = free_ff;
      words_in     = words_ff;
      missed_in    = missed_ff;
      ovf_in       = ovf_ff;
      load_in      = load_ff;
      sym_in       = sym_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      mem            = '0;
      mem.link_addr  = addr_ff;
      mem.link_wdata = free_ff[NODE_W-1:0];
      mem.mark_addr  = node_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               load_in       = req_payload.action;
               sym_in        = req_sym;
               addr_in       = LINK_AW'(node_ff) * LINK_AW'(SYMBOL_SLOTS) + LINK_AW'(req_sym);
               mem.link_re   = 1'b1;
               mem.link_addr = addr_in;
               mem.mark_re   = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stall) begin
               state_in = ST_IDLE;
               if (sym_ff != SYM_END) begin
                  if (load_ff == ACT_LOAD) begin
                     if (!ovf_ff) begin
                        if (link_rdata != '0) begin
                           node_in = link_rdata;
                        end else if (free_ff < FREE_W'(NODE_COUNT)) begin
                           mem.link_we = 1'b1;
                           node_in     = free_ff[NODE_W-1:0];
                           free_in     = free_ff + FREE_W'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end else if (!missed_ff) begin
                     if (link_rdata == '0) begin
                        missed_in = 1'b1;
                     end else begin
                        node_in = link_rdata;
                     end
                  end
               end else begin
                  node_in   = '0;
                  missed_in = 1'b0;
                  ovf_in    = 1'b0;
                  if (has_result) begin
                     rsp_valid_in = 1'b1;
                     if (load_ff == ACT_LOAD) begin
                        if (!ovf_ff && !mark_eff) begin
                           mem.mark_we = 1'b1;
                           if (words_ff != WORD_MAX) begin
                              words_in = words_ff + WORD_W'(1);
                           end
                        end
                        rsp_data_in.found     = 1'b0;
                        rsp_data_in.pool_full = ovf_ff;
                        rsp_data_in.was_load  = 1'b1;
                     end else begin
                        rsp_data_in.found     = !missed_ff && mark_eff;
                        rsp_data_in.pool_full = 1'b0;
                        rsp_data_in.was_load  = 1'b0;
                     end
                     rsp_data_in.word_total = words_in;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         node_ff      <= '0;
         free_ff      <= FREE_W'(1);
         words_ff     <= '0;
         missed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         free_ff      <= free_in;
         words_ff     <= words_in;
         missed_ff    <= missed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      load_ff     <= load_in;
      sym_ff      <= sym_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/trie_word_insert_lookup.sv =====
// -----------------------------------------------------------------------------
// trie_word_insert_lookup
// Trie dictionary: load and check words one character per transaction.
//
//   channel  ports        direction  content
//   req      req_*        in         action, char_code
//   rsp      rsp_*        out        found, word_total, pool_full, was_load
//
// Each character is a link/mark RAM read in ST_IDLE, then decide and write back
// in ST_EXEC; no new character is taken before ST_IDLE. After reset a clearing
// sweep zeroes all 28672 (NODE_COUNT*SYMBOL_SLOTS) links, with req_ready low.
// A word end that yields a response waits in ST_EXEC while the output register
// holds an untaken transaction; other characters never stall.
// -----------------------------------------------------------------------------
`default_nettype none

module trie_word_insert_lookup
   import twil_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   clr_type            clr;
   mem_req_type        mem;
   logic [NODE_W-1:0]  link_rdata;
   logic               mark_rdata;
   logic               link_we, link_re, mark_we, mark_re;
   logic [LINK_AW-1:0] link_addr;
   logic [NODE_W-1:0]  link_wdata, mark_addr;
   logic               mark_wdata;

   twil_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   twil_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .clr_busy    (clr.busy),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem         (mem),
      .link_rdata  (link_rdata),
      .mark_rdata  (mark_rdata)
   );

   always_comb begin
      if (clr.busy) begin
         link_we    = 1'b1;
         link_re    = 1'b0;
         link_addr  = clr.addr;
         link_wdata = '0;
         mark_we    = clr.addr < LINK_AW'(NODE_COUNT);
         mark_re    = 1'b0;
         mark_addr  = clr.addr[NODE_W-1:0];
         mark_wdata = 1'b0;
      end else begin
         link_we    = mem.link_we;
         link_re    = mem.link_re;
         link_addr  = mem.link_addr;
         link_wdata = mem.link_wdata;
         mark_we    = mem.mark_we;
         mark_re    = mem.mark_re;
         mark_addr  = mem.mark_addr;
         mark_wdata = 1'b1;
      end
   end

   twil_ram #(
      .WIDTH (NODE_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .re    (link_re),
      .addr  (link_addr),
      .wdata (link_wdata),
      .rdata (link_rdata)
   );

   twil_ram #(
      .WIDTH (1),
      .DEPTH (NODE_COUNT)
   ) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .re    (mark_re),
      .addr  (mark_addr),
      .wdata (mark_wdata),
      .rdata (mark_rdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/twil_checker.sv =====
// -----------------------------------------------------------------------------
// twil_checker
// Port-level checks of the trie dictionary, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twil_checker
   import twil_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   logic req_fire;
   logic rsp_stuck;
   logic load_rsp;

   assign req_fire  = req_valid && req_ready && (req_payload.action == ACT_LOAD ||
                      req_payload.action == ACT_CHECK);
   assign rsp_stuck = rsp_valid && !rsp_ready;
   assign load_rsp  = rsp_valid && rsp_payload.was_load;

   `ASSERT_NEXT(a_no_back_to_back, clock, reset, req_fire, !req_ready)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stuck, rsp_valid && $stable(rsp_payload))
   `ASSERT_IMPLIES(a_load_not_found, clock, reset, load_rsp, !rsp_payload.found)
   `ASSERT_IMPLIES(a_rsp_after_req, clock, reset, $rose(rsp_valid), $past(req_fire, 2))

endmodule

bind trie_word_insert_lookup twil_checker u_twil_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
